>>> rtl/core/jsu_pkg.sv
// Shared types, status codes and byte-job helpers for the JSON string unescaper.
// No dependencies; every other file in rtl/core depends on this package.
package jsu_pkg;

  localparam int BYTE_W          = 8;
  localparam int STATUS_W        = 4;
  localparam int JSU_QUEUE_DEPTH = 4;

  localparam logic [STATUS_W-1:0] ST_DATA         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_END          = 4'd1;
  localparam logic [STATUS_W-1:0] ST_CTRL_CHAR    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX      = 4'd4;
  localparam logic [STATUS_W-1:0] ST_MISSING_LOW  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_LOW      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_LONE_LOW     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_UNTERMINATED = 4'd8;

  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LOWER_B   = 8'h62;
  localparam logic [BYTE_W-1:0] CH_LOWER_F   = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LOWER_N   = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOWER_R   = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOWER_T   = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LOWER_U   = 8'h75;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  // One queue entry: up to four result bytes sharing one status.
  typedef struct packed {
    logic [1:0]                   last_idx;
    logic [STATUS_W-1:0]          status;
    logic [3:0][BYTE_W-1:0]       bytes;
  } jsu_job_t;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_of(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic jsu_job_t byte_job(input logic [BYTE_W-1:0] b);
    jsu_job_t j;
    j = '0;
    j.status   = ST_DATA;
    j.bytes[0] = b;
    return j;
  endfunction

  function automatic jsu_job_t err_job(input logic [STATUS_W-1:0] st);
    jsu_job_t j;
    j = '0;
    j.status = st;
    return j;
  endfunction

  function automatic jsu_job_t utf8_job(input logic [20:0] cp);
    jsu_job_t j;
    j = '0;
    j.status = ST_DATA;
    if (cp <= 21'h7F) begin
      j.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      j.last_idx = 2'd1;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      j.last_idx = 2'd2;
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      j.last_idx = 2'd3;
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

endpackage

>>> rtl/core/jsu_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
// Depends on jsu_pkg for field widths.
interface jsu_in_if;
  logic                         valid;
  logic                         ready;
  logic [jsu_pkg::BYTE_W-1:0]   in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic                         valid;
  logic                         ready;
  logic [jsu_pkg::BYTE_W-1:0]   out_byte;
  logic [jsu_pkg::STATUS_W-1:0] status;
  logic                         last;
  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

>>> rtl/core/jsu_front.sv
// Front end: escape/surrogate state machine, one input byte per cycle while push_ready
// is high; turns each byte into at most one byte job. Depends on jsu_pkg.
module jsu_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [jsu_pkg::BYTE_W-1:0] in_byte,
  output logic                     in_ready,
  output logic                     push_valid,
  output jsu_pkg::jsu_job_t        push_job,
  input  logic                     push_ready
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_CONTENT, PH_ESCAPE, PH_HEX_A, PH_WANT_BS, PH_WANT_U, PH_HEX_B
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [11:0] hex_r, hex_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hh_r, hh_nxt;

  logic        accept;
  logic        has_job;
  jsu_job_t    job;
  logic [4:0]  hx;
  logic [15:0] word;
  logic [20:0] supp_cp;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && has_job;
  assign push_job   = job;

  assign hx      = hex_of(in_byte);
  assign word    = {hex_r, hx[3:0]};
  assign supp_cp = SUPP_BASE + {1'b0, hh_r, word[9:0]};

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    cnt_nxt   = cnt_r;
    hh_nxt    = hh_r;
    has_job   = 1'b0;
    job       = '0;
    unique case (phase_r)
      PH_ESCAPE: begin
        phase_nxt = PH_CONTENT;
        has_job   = 1'b1;
        unique case (in_byte) inside
          CH_QUOTE, CH_BACKSLASH, CH_SLASH: job = byte_job(in_byte);
          CH_LOWER_B: job = byte_job(8'h08);
          CH_LOWER_F: job = byte_job(8'h0C);
          CH_LOWER_N: job = byte_job(8'h0A);
          CH_LOWER_R: job = byte_job(8'h0D);
          CH_LOWER_T: job = byte_job(8'h09);
          CH_LOWER_U: begin
            has_job   = 1'b0;
            phase_nxt = PH_HEX_A;
            hex_nxt   = '0;
            cnt_nxt   = '0;
          end
          default: job = err_job(ST_BAD_ESCAPE);
        endcase
      end
      PH_HEX_A, PH_HEX_B: begin
        if (!hx[4]) begin
          has_job   = 1'b1;
          job       = err_job(ST_BAD_HEX);
          phase_nxt = PH_CONTENT;
        end else if (cnt_r == 2'd3) begin
          cnt_nxt   = '0;
          hex_nxt   = '0;
          phase_nxt = PH_CONTENT;
          if (phase_r == PH_HEX_A) begin
            if (word >= HIGH_SURR_MIN && word <= HIGH_SURR_MAX) begin
              hh_nxt    = word[9:0];
              phase_nxt = PH_WANT_BS;
            end else if (word >= LOW_SURR_MIN && word <= LOW_SURR_MAX) begin
              has_job = 1'b1;
              job     = err_job(ST_LONE_LOW);
            end else begin
              has_job = 1'b1;
              job     = utf8_job({5'd0, word});
            end
          end else begin
            has_job = 1'b1;
            if (word >= LOW_SURR_MIN && word <= LOW_SURR_MAX) begin
              job = utf8_job(supp_cp);
            end else begin
              job = err_job(ST_BAD_LOW);
            end
          end
        end else begin
          hex_nxt = word[11:0];
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_WANT_BS: begin
        if (in_byte == CH_BACKSLASH) begin
          phase_nxt = PH_WANT_U;
        end else begin
          has_job   = 1'b1;
          job       = err_job(ST_MISSING_LOW);
          phase_nxt = PH_CONTENT;
        end
      end
      PH_WANT_U: begin
        if (in_byte == CH_LOWER_U) begin
          phase_nxt = PH_HEX_B;
          hex_nxt   = '0;
          cnt_nxt   = '0;
        end else begin
          has_job   = 1'b1;
          job       = err_job(ST_MISSING_LOW);
          phase_nxt = PH_CONTENT;
        end
      end
      default: begin
        phase_nxt = PH_CONTENT;
        if (in_byte == CH_NUL) begin
          has_job = 1'b1;
          job     = err_job(ST_UNTERMINATED);
        end else if (in_byte == CH_QUOTE) begin
          has_job = 1'b1;
          job     = err_job(ST_END);
        end else if (in_byte < CH_SPACE) begin
          has_job = 1'b1;
          job     = err_job(ST_CTRL_CHAR);
        end else if (in_byte == CH_BACKSLASH) begin
          phase_nxt = PH_ESCAPE;
        end else begin
          has_job = 1'b1;
          job     = byte_job(in_byte);
        end
      end
    endcase
    if (phase_nxt == PH_CONTENT) begin
      hex_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CONTENT;
      hex_r   <= '0;
      cnt_r   <= '0;
      hh_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      cnt_r   <= cnt_nxt;
      hh_r    <= hh_nxt;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_job.status != ST_DATA |-> push_job.last_idx == 2'd0)
    else $error("error job carries more than one byte");

  a_multi_from_hex: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_job.last_idx != 2'd0 |-> phase_r == PH_HEX_A || phase_r == PH_HEX_B)
    else $error("multi-byte job outside a hex phase");

  a_four_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_job.last_idx == 2'd3 |-> phase_r == PH_HEX_B)
    else $error("four-byte sequence without a surrogate pair");

endmodule

>>> rtl/core/jsu_queue.sv
// Short flip-flop queue of byte jobs between front and back end.
// Depends on jsu_pkg for the job type.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  jsu_pkg::jsu_job_t push_job,
  output logic              push_ready,
  output logic              pop_valid,
  output jsu_pkg::jsu_job_t pop_job,
  input  logic              pop_ready
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_job_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CNT_W'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/jsu_back.sv
// Back end: walks the bytes of the head job, one result per cycle while out_ready
// allows, into a registered output stage. Depends on jsu_pkg.
module jsu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  jsu_pkg::jsu_job_t            job,
  output logic                         job_pop,
  output logic                         out_valid,
  output logic [jsu_pkg::BYTE_W-1:0]   out_byte,
  output logic [jsu_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last,
  input  logic                         out_ready
);
  import jsu_pkg::*;

  logic [1:0]          idx_r;
  logic                valid_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [STATUS_W-1:0] status_r;
  logic                last_r;
  logic                load, at_last;

  assign load       = job_valid && (!valid_r || out_ready);
  assign at_last    = (idx_r == job.last_idx);
  assign job_pop    = load && at_last;
  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_status = status_r;
  assign out_last   = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= job.bytes[idx_r];
      status_r <= job.status;
      last_r   <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  a_idx_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> job_valid && idx_r <= job.last_idx)
    else $error("byte index beyond head job");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> valid_r && last_r)
    else $error("job popped without final result");

endmodule

>>> rtl/core/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
//   channel  | dir | payload                         | handshake
//   in_ch    | in  | in_byte[7:0]                    | valid/ready, transfer on both high
//   out_ch   | out | out_byte[7:0] status[3:0] last  | valid/ready, transfer on both high
//
// One input byte transfers per cycle while the job queue has room.
// Each byte yields at most one job of one to four results; the back end emits one
// result per cycle while out_ch.ready allows, so a \u escape of n UTF-8 bytes gives n results.
// An input byte passes through the job queue and the back end's output register before its first result.
// Synchronous active-low reset empties the queue and returns to content phase.
// Output stalls back up through the queue to in_ch.ready.
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);
  import jsu_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  jsu_job_t push_job, pop_job;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.in_byte),
    .in_ready   (in_ch.ready),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (pop_valid),
    .job        (pop_job),
    .job_pop    (pop_ready),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .out_status (out_ch.status),
    .out_last   (out_ch.last),
    .out_ready  (out_ch.ready)
  );

endmodule
